// ===== sv/mltt_pkg.sv =====
// Package for the multi-level thermal throttle: level and config types,
// register indexes, reset values and the release-point helper.
// No dependencies.
`default_nettype none

package mltt_pkg;

    // number of throttle levels requested and the number of register pairs
    localparam int LEVELS      = 4;
    localparam int NREG_LEVELS = 4;
    localparam int NLEV        = (LEVELS < NREG_LEVELS) ? LEVELS : NREG_LEVELS;

    // degrees removed from a level's threshold to get its release point
    localparam int HYSTERESIS  = 5;

    // field widths
    localparam int TEMP_W  = 8;
    localparam int FREQ_W  = 22;
    localparam int LEVEL_W = 3;
    localparam int IDX_W   = 3;
    localparam int LIDX_W  = 2;

    // stream payload widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [TEMP_W-1:0]         t_temp;
    typedef logic [FREQ_W-1:0]         t_freq;
    typedef logic [IDX_W-1:0]          t_reg_idx;

    localparam t_level LEVEL_NONE = t_level'(-1);
    localparam t_level LEVEL_TOP  = t_level'(NLEV - 1);
    localparam t_temp  HYST_DEG   = t_temp'(HYSTERESIS);

    // configuration register indexes
    localparam t_reg_idx REG_THRESHOLD_0 = 3'd0;
    localparam t_reg_idx REG_THRESHOLD_1 = 3'd1;
    localparam t_reg_idx REG_THRESHOLD_2 = 3'd2;
    localparam t_reg_idx REG_THRESHOLD_3 = 3'd3;
    localparam t_reg_idx REG_CAP_FREQ_0  = 3'd4;
    localparam t_reg_idx REG_CAP_FREQ_1  = 3'd5;
    localparam t_reg_idx REG_CAP_FREQ_2  = 3'd6;
    localparam t_reg_idx REG_CAP_FREQ_3  = 3'd7;

    // register reset values
    localparam t_temp THRESHOLD_0_RST = 8'd80;
    localparam t_temp THRESHOLD_1_RST = 8'd85;
    localparam t_temp THRESHOLD_2_RST = 8'd92;
    localparam t_temp THRESHOLD_3_RST = 8'd102;
    localparam t_freq CAP_FREQ_0_RST  = 22'd1512000;
    localparam t_freq CAP_FREQ_1_RST  = 22'd1350000;
    localparam t_freq CAP_FREQ_2_RST  = 22'd918000;
    localparam t_freq CAP_FREQ_3_RST  = 22'd384000;

    // register file contents seen by the level logic
    typedef struct packed {
        t_temp [NREG_LEVELS-1:0] threshold;
        t_freq [NREG_LEVELS-1:0] cap_freq;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_temp  release_temp_out;
        logic   release_valid;
        t_temp  trip_temp;
        logic   trip_valid;
        t_freq  max_freq_khz;
        logic   freq_limited;
        logic   level_changed;
        t_level level;
    } t_result;

    // threshold minus hysteresis, clamped at zero
    function automatic t_temp release_point(input t_temp thr);
        return (thr >= HYST_DEG) ? t_temp'(thr - HYST_DEG) : '0;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mltt_cfg_regs.sv =====
// Configuration register file for the thermal throttle: four thresholds
// and four frequency caps behind a plain write port.
// Depends on mltt_pkg.
`default_nettype none

module mltt_cfg_regs
    import mltt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire t_reg_idx i_cfg_index,
    input  wire t_freq    i_cfg_wdata,
    output t_cfg          o_cfg
);

    t_temp [NREG_LEVELS-1:0] r_threshold;
    t_freq [NREG_LEVELS-1:0] r_cap_freq;

    // register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold[0] <= THRESHOLD_0_RST;
            r_threshold[1] <= THRESHOLD_1_RST;
            r_threshold[2] <= THRESHOLD_2_RST;
            r_threshold[3] <= THRESHOLD_3_RST;
            r_cap_freq[0]  <= CAP_FREQ_0_RST;
            r_cap_freq[1]  <= CAP_FREQ_1_RST;
            r_cap_freq[2]  <= CAP_FREQ_2_RST;
            r_cap_freq[3]  <= CAP_FREQ_3_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD_0: r_threshold[0] <= i_cfg_wdata[TEMP_W-1:0];
                REG_THRESHOLD_1: r_threshold[1] <= i_cfg_wdata[TEMP_W-1:0];
                REG_THRESHOLD_2: r_threshold[2] <= i_cfg_wdata[TEMP_W-1:0];
                REG_THRESHOLD_3: r_threshold[3] <= i_cfg_wdata[TEMP_W-1:0];
                REG_CAP_FREQ_0:  r_cap_freq[0]  <= i_cfg_wdata;
                REG_CAP_FREQ_1:  r_cap_freq[1]  <= i_cfg_wdata;
                REG_CAP_FREQ_2:  r_cap_freq[2]  <= i_cfg_wdata;
                REG_CAP_FREQ_3:  r_cap_freq[3]  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg.threshold = r_threshold;
    assign o_cfg.cap_freq  = r_cap_freq;

endmodule

`default_nettype wire

// ===== sv/mltt_level_calc.sv =====
// Combinational level decision for one reading: threshold compares,
// hysteresis release test and result field lookup.
// Depends on mltt_pkg.
`default_nettype none

module mltt_level_calc
    import mltt_pkg::*;
(
    input  wire t_cfg    i_cfg,
    input  wire t_temp   i_temp,
    input  wire logic    i_read_failed,
    input  wire t_level  i_prev_level,
    output t_level       o_next_level,
    output t_result      o_result
);

    t_level cand;
    t_temp  prev_release;
    t_level lvl;
    t_level lvl_up;

    // candidate: highest level whose threshold is reached
    always_comb begin
        cand = LEVEL_NONE;
        for (int i = 0; i < NLEV; i++) begin
            if (i_temp >= i_cfg.threshold[i]) begin
                cand = t_level'(i);
            end
        end
    end

    // rise at once, fall only at or below the current release point
    always_comb begin
        prev_release = (i_prev_level == LEVEL_NONE) ? '0 :
            release_point(i_cfg.threshold[i_prev_level[LIDX_W-1:0]]);
        lvl = i_prev_level;
        if (!i_read_failed && ((cand > i_prev_level) || (i_temp <= prev_release))) begin
            lvl = cand;
        end
    end

    assign lvl_up       = t_level'(lvl + t_level'(1));
    assign o_next_level = lvl;

    // result fields for the new level
    always_comb begin
        o_result.level         = lvl;
        o_result.level_changed = (lvl != i_prev_level);
        o_result.freq_limited  = (lvl != LEVEL_NONE);
        o_result.max_freq_khz  = (lvl != LEVEL_NONE) ?
            i_cfg.cap_freq[lvl[LIDX_W-1:0]] : '0;
        o_result.trip_valid    = (lvl < LEVEL_TOP);
        o_result.trip_temp     = (lvl < LEVEL_TOP) ?
            i_cfg.threshold[lvl_up[LIDX_W-1:0]] : '0;
        o_result.release_valid = (lvl != LEVEL_NONE);
        o_result.release_temp_out = (lvl != LEVEL_NONE) ?
            release_point(i_cfg.threshold[lvl[LIDX_W-1:0]]) : '0;
    end

endmodule

`default_nettype wire

// ===== sv/multi_level_thermal_throttle.sv =====
// Top level of the multi-level thermal throttle: input register, level
// logic, level state and result register with stream handshakes.
// Depends on mltt_pkg, mltt_cfg_regs and mltt_level_calc.
`default_nettype none

// Takes one temperature reading per item and reports a throttle level from
// -1 (unthrottled) to 3 with hysteresis, the frequency cap for that level and
// the next trip and release points. One item is accepted every cycle unless
// the result stream stalls; items pass the input and then the result register.
// The rate is set by the loop through the level register: each reading is
// decided against the level left by the one before. While a result waits,
// only an empty input register takes an item. The user must write registers
// via the plain write port only while no item is in flight; not enforced.
module multi_level_thermal_throttle
    import mltt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] temperature
    input  wire logic [0:0]            s_axis_tuser,   // [0] read_failed
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [2:0] level, [3] level_changed, [4] freq_limited, [26:5] max_freq_khz,
    // [27] trip_valid, [35:28] trip_temp, [36] release_valid,
    // [44:37] release_temp_out, [47:45] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire t_reg_idx              i_cfg_index,
    input  wire t_freq                 i_cfg_wdata
);

    t_cfg    cfg;
    t_level  next_level;
    t_result result;
    logic    advance;

    logic    r_in_valid;
    t_temp   r_in_temp;
    logic    r_in_failed;
    t_level  r_level;
    logic    r_out_valid;
    t_result r_out;

    mltt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mltt_level_calc u_calc (
        .i_cfg         (cfg),
        .i_temp        (r_in_temp),
        .i_read_failed (r_in_failed),
        .i_prev_level  (r_level),
        .o_next_level  (next_level),
        .o_result      (result)
    );

    // the result register moves when empty or when its item is taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_temp   <= s_axis_tdata[TEMP_W-1:0];
            r_in_failed <= s_axis_tuser[0];
        end
    end

    // level state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LEVEL_NONE;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_level <= next_level;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule

`default_nettype wire

// ===== sv/mltt_checker.sv =====
// Port-level checker for the thermal throttle, bound to the top level.
// Depends on mltt_pkg and multi_level_thermal_throttle.
`default_nettype none

module mltt_checker
    import mltt_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_result res;
    assign res = m_axis_tdata[$bits(t_result)-1:0];

    // no result right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // cap and release point exist exactly when throttled
    a_throttled_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.freq_limited == res.release_valid) &&
                          (res.freq_limited == (res.level != LEVEL_NONE)))
        else $error("throttle flags disagree with level");

    // unthrottled result carries no cap and no release point, but a valid trip point
    a_unthrottled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.freq_limited |->
            (res.max_freq_khz == '0) && (res.release_temp_out == '0) && res.trip_valid)
        else $error("unthrottled result has nonzero cap or release point");

    // an invalid trip point is zero and is reported only at the top level
    a_trip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.trip_valid |->
            (res.trip_temp == '0) && (res.level == LEVEL_TOP))
        else $error("invalid trip point not at top level");

endmodule

bind multi_level_thermal_throttle mltt_checker u_mltt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
